>>> rtl/core/lsag_pkg.sv
// lsag_pkg: shared types, register map and constants for the latency spike governor
// no dependencies; used by every module of the block except lsag_mul
`timescale 1ns / 1ps
`default_nettype none
package lsag_pkg;

  // fixed field widths
  localparam int MS_BITS    = 16;
  localparam int DRIVE_BITS = 3;
  localparam int PAR_BITS   = 9;
  localparam int DELAY_BITS = 8;
  localparam int RUN_BITS   = 4;
  localparam int CNT_BITS   = 16;
  localparam int MEAN_BITS  = 32;
  localparam int SPREAD_BITS = 64;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  // default depth of the per-drive store
  localparam int DRIVES_DEF = 8;

  // register reset values
  localparam logic [PAR_BITS-1:0]   CORE_COUNT_RST   = 9'd8;
  localparam logic [MS_BITS-1:0]    HARD_LIMIT_RST   = 16'd1000;
  localparam logic [MS_BITS-1:0]    SOFT_FLOOR_RST   = 16'd500;
  localparam logic [CNT_BITS-1:0]   MIN_SAMPLES_RST  = 16'd10;
  localparam logic [RUN_BITS-1:0]   RAMP_READS_RST   = 4'd3;
  localparam logic [DELAY_BITS-1:0] BACKOFF_RST      = 8'd20;

  // governor constants
  localparam logic [PAR_BITS-1:0] PAR_RST   = 9'd4;
  localparam logic [PAR_BITS-1:0] PAR_FLOOR = 9'd2;
  localparam logic [PAR_BITS-1:0] PAR_CEIL_MIN = 9'd4;
  localparam logic [RUN_BITS-1:0] RUN_MAX   = 4'd15;
  localparam logic [CNT_BITS-1:0] CNT_MAX   = 16'hFFFF;
  localparam logic [CNT_BITS-1:0] WARN_LVL0 = 16'd10;
  localparam logic [CNT_BITS-1:0] WARN_LVL1 = 16'd30;
  localparam logic [CNT_BITS-1:0] WARN_LVL2 = 16'd60;
  localparam int DIV_STEPS = 32;

  // register indexes (paddr[4:2])
  typedef enum logic [2:0] {
    REG_CORE_COUNT = 3'd0,
    REG_HARD_LIMIT = 3'd1,
    REG_SOFT_FLOOR = 3'd2,
    REG_MIN_SAMPLES = 3'd3,
    REG_RAMP_READS = 3'd4,
    REG_BACKOFF    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [DRIVE_BITS-1:0] drive;
    logic [MS_BITS-1:0]    elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic                  spike;
    logic [PAR_BITS-1:0]   concurrency;
    logic                  concurrency_changed;
    logic [DELAY_BITS-1:0] throttle_ms;
    logic                  drive_warning;
    logic [CNT_BITS-1:0]   anomaly_total;
    logic [MS_BITS-1:0]    mean_ms;
  } out_item_t;

  // one drive's statistics
  typedef struct packed {
    logic [CNT_BITS-1:0]    samples;
    logic [MEAN_BITS-1:0]   mean;
    logic [SPREAD_BITS-1:0] spread;
    logic [CNT_BITS-1:0]    spikes;
  } drive_stats_t;

  // divider control and status
  typedef struct packed {
    logic                 start;
    logic [MEAN_BITS-1:0] dividend;
    logic [CNT_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [MEAN_BITS-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/lsag_div.sv
// lsag_div: radix-2 restoring divider, 32-bit dividend by 16-bit divisor
// depends on lsag_pkg
`timescale 1ns / 1ps
`default_nettype none
module lsag_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lsag_pkg::div_req_t req,
  output lsag_pkg::div_rsp_t     rsp
);

  localparam int CW = $clog2(lsag_pkg::DIV_STEPS + 1);

  logic [CW-1:0]                     steps;
  logic [lsag_pkg::CNT_BITS-1:0]     rem;
  logic [lsag_pkg::MEAN_BITS-1:0]    quo;
  logic [lsag_pkg::CNT_BITS-1:0]     dvs;
  logic                              done;
  logic [lsag_pkg::CNT_BITS:0]       shifted;
  logic [lsag_pkg::CNT_BITS:0]       trial;

  // one quotient bit per cycle
  always_comb begin
    shifted = {rem, quo[lsag_pkg::MEAN_BITS-1]};
    trial   = shifted - {1'b0, dvs};
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (req.start) begin
      steps <= CW'(lsag_pkg::DIV_STEPS);
      done  <= 1'b0;
    end else begin
      done <= (steps == CW'(1));
      if (steps != '0) steps <= steps - CW'(1);
    end
  end

  // partial remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (steps != '0) begin
      if (!trial[lsag_pkg::CNT_BITS]) begin
        rem <= trial[lsag_pkg::CNT_BITS-1:0];
        quo <= {quo[lsag_pkg::MEAN_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[lsag_pkg::CNT_BITS-1:0];
        quo <= {quo[lsag_pkg::MEAN_BITS-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

>>> rtl/core/lsag_mul.sv
// lsag_mul: shared 32x32 multiplier with registered product
// depends on nothing beyond the clock
`timescale 1ns / 1ps
`default_nettype none
module lsag_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p
);

  // product register
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

>>> rtl/core/lsag_store.sv
// lsag_store: per-drive statistics memory with registered read and valid flags
// depends on lsag_pkg
`timescale 1ns / 1ps
`default_nettype none
module lsag_store #(
  parameter int DRIVES = lsag_pkg::DRIVES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DRIVES)-1:0]  rd_idx,
  output lsag_pkg::drive_stats_t          rd_data,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DRIVES)-1:0]  wr_idx,
  input  wire lsag_pkg::drive_stats_t     wr_data
);

  lsag_pkg::drive_stats_t mem [DRIVES];
  logic [DRIVES-1:0]      filled;
  lsag_pkg::drive_stats_t rd_q;
  logic                   rd_ok;

  // write port and read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (rd_en) rd_q <= mem[rd_idx];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (wr_en) filled[wr_idx] <= 1'b1;
      if (rd_en) rd_ok <= filled[rd_idx];
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule
`default_nettype wire

>>> rtl/core/latency_spike_aimd_governor_core.sv
// latency_spike_aimd_governor_core: top level, sequencer, governor state and config port
// depends on lsag_pkg, lsag_store, lsag_div, lsag_mul
`timescale 1ns / 1ps
`default_nettype none
// One read transfer is taken at a time. After acceptance the item passes through the
// store read, the divider state (32 radix-2 quotient steps for the running-mean
// update, then waiting for done), the mean and deviation steps, four passes through
// the shared 32x32 multiplier plus a step to fold the last product, the compare and
// the finish state. in_stall stays high for the whole item. A finished result sits
// in an output register, so the next read is accepted while it waits; that next item
// then holds in its finish state until the waiting result is taken.
// Per-drive statistics start at zero after reset with no clearing pass.
// Registers sit at byte addresses 0,4,..,20 and should be written only while idle.
module latency_spike_aimd_governor_core #(
  parameter int DRIVES = lsag_pkg::DRIVES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire lsag_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output lsag_pkg::out_item_t                      out_data,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lsag_pkg::ADDR_BITS-1:0]      paddr,
  input  wire logic [lsag_pkg::DATA_BITS-1:0]      pwdata,
  output logic [lsag_pkg::DATA_BITS-1:0]           prdata,
  output logic                                     pready
);

  localparam int IW = $clog2(DRIVES);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_LOAD = 12'b000000000010,
    S_DIV  = 12'b000000000100,
    S_MEAN = 12'b000000001000,
    S_DEV  = 12'b000000010000,
    S_P1   = 12'b000000100000,
    S_P2   = 12'b000001000000,
    S_P3   = 12'b000010000000,
    S_P4   = 12'b000100000000,
    S_P5   = 12'b001000000000,
    S_CMP  = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [lsag_pkg::PAR_BITS-1:0]   core_count;
  logic [lsag_pkg::MS_BITS-1:0]    hard_limit;
  logic [lsag_pkg::MS_BITS-1:0]    soft_floor;
  logic [lsag_pkg::CNT_BITS-1:0]   min_samples;
  logic [lsag_pkg::RUN_BITS-1:0]   ramp_reads;
  logic [lsag_pkg::DELAY_BITS-1:0] backoff;
  logic                            cfg_wr;
  lsag_pkg::reg_idx_t              reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = lsag_pkg::reg_idx_t'(paddr[4:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      core_count  <= lsag_pkg::CORE_COUNT_RST;
      hard_limit  <= lsag_pkg::HARD_LIMIT_RST;
      soft_floor  <= lsag_pkg::SOFT_FLOOR_RST;
      min_samples <= lsag_pkg::MIN_SAMPLES_RST;
      ramp_reads  <= lsag_pkg::RAMP_READS_RST;
      backoff     <= lsag_pkg::BACKOFF_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        lsag_pkg::REG_CORE_COUNT:  core_count  <= pwdata[8:0];
        lsag_pkg::REG_HARD_LIMIT:  hard_limit  <= pwdata[15:0];
        lsag_pkg::REG_SOFT_FLOOR:  soft_floor  <= pwdata[15:0];
        lsag_pkg::REG_MIN_SAMPLES: min_samples <= pwdata[15:0];
        lsag_pkg::REG_RAMP_READS:  ramp_reads  <= pwdata[3:0];
        lsag_pkg::REG_BACKOFF:     backoff     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_sel)
      lsag_pkg::REG_CORE_COUNT:  prdata = 32'(core_count);
      lsag_pkg::REG_HARD_LIMIT:  prdata = 32'(hard_limit);
      lsag_pkg::REG_SOFT_FLOOR:  prdata = 32'(soft_floor);
      lsag_pkg::REG_MIN_SAMPLES: prdata = 32'(min_samples);
      lsag_pkg::REG_RAMP_READS:  prdata = 32'(ramp_reads);
      lsag_pkg::REG_BACKOFF:     prdata = 32'(backoff);
      default:                   prdata = '0;
    endcase
  end

  // drive index reduced into the store depth
  logic [IW-1:0] idx_in;
  generate
    if (DRIVES >= 8) begin : g_wide
      assign idx_in = IW'(in_data.drive);
    end else begin : g_fold
      logic [3:0] r;
      always_comb begin
        r = {1'b0, in_data.drive};
        for (int i = 0; i < 3; i++) begin
          if (r >= 4'(DRIVES)) r = r - 4'(DRIVES);
        end
      end
      assign idx_in = IW'(r);
    end
  endgenerate

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // per-drive store
  lsag_pkg::drive_stats_t st_rd, st_wr;
  logic                   st_we;
  logic [IW-1:0]          idx;

  lsag_store #(.DRIVES(DRIVES)) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_idx  (idx_in),
    .rd_data (st_rd),
    .wr_en   (st_we),
    .wr_idx  (idx),
    .wr_data (st_wr)
  );

  // item working registers
  logic [lsag_pkg::MS_BITS-1:0]     el;
  logic [lsag_pkg::CNT_BITS-1:0]    n;
  logic [lsag_pkg::CNT_BITS-1:0]    nm1;
  logic [lsag_pkg::MEAN_BITS-1:0]   mean;
  logic [lsag_pkg::SPREAD_BITS-1:0] spread;
  logic [lsag_pkg::CNT_BITS-1:0]    spikes;
  logic                             d_neg;
  logic [31:0]                      d_mag;
  logic [31:0]                      nm;
  logic                             d2_pos;
  logic [31:0]                      d2_mag;
  logic [63:0]                      spread_new;
  logic [67:0]                      rhs9;
  logic [31:0]                      sq_hi;
  logic [47:0]                      lo_prod;
  logic [79:0]                      lhs;
  logic                             stat_hit;

  logic [31:0] x;
  assign x = {el, 16'h0000};

  // load-stage arithmetic
  logic [lsag_pkg::CNT_BITS-1:0] n_ld;
  logic [32:0]                   delta_ld;
  logic [31:0]                   dmag_ld;
  always_comb begin
    n_ld     = (st_rd.samples != lsag_pkg::CNT_MAX) ? st_rd.samples + 16'd1 : st_rd.samples;
    delta_ld = {1'b0, x} - {1'b0, st_rd.mean};
    dmag_ld  = delta_ld[32] ? 32'(-delta_ld) : delta_ld[31:0];
  end

  // divider
  lsag_pkg::div_req_t div_req;
  lsag_pkg::div_rsp_t div_rsp;
  assign div_req.start    = (state == S_LOAD);
  assign div_req.dividend = dmag_ld;
  assign div_req.divisor  = n_ld;

  lsag_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    case (state)
      S_P1:    begin mul_a = d_mag;        mul_b = d2_mag;      end
      S_P2:    begin mul_a = d2_mag;       mul_b = d2_mag;      end
      S_P3:    begin mul_a = mul_p[31:0];  mul_b = 32'(nm1);    end
      S_P4:    begin mul_a = sq_hi;        mul_b = 32'(nm1);    end
      default: begin mul_a = d_mag;        mul_b = d2_mag;      end
    endcase
  end

  lsag_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // deviation from the updated mean
  logic [32:0] d2_w;
  assign d2_w = {1'b0, x} - {1'b0, nm};

  // spread accumulate with saturation
  logic [64:0] spread_sum;
  assign spread_sum = {1'b0, spread} + 65'(mul_p[63:16]);

  // datapath registers per state
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          idx <= idx_in;
          el  <= in_data.elapsed_ms;
        end
      end
      S_LOAD: begin
        n      <= n_ld;
        nm1    <= n_ld - 16'd1;
        mean   <= st_rd.mean;
        spread <= st_rd.spread;
        spikes <= st_rd.spikes;
        d_neg  <= delta_ld[32];
        d_mag  <= dmag_ld;
      end
      S_MEAN: nm <= d_neg ? mean - div_rsp.quotient : mean + div_rsp.quotient;
      S_DEV: begin
        d2_pos <= !d2_w[32] && (d2_w != '0);
        d2_mag <= d2_w[32] ? 32'(-d2_w) : d2_w[31:0];
      end
      S_P2: spread_new <= spread_sum[64] ? '1 : spread_sum[63:0];
      S_P3: begin
        sq_hi <= mul_p[63:32];
        rhs9  <= {1'b0, spread_new, 3'b000} + 68'(spread_new);
      end
      S_P4: lo_prod <= mul_p[47:0];
      S_P5: lhs <= {mul_p[47:0], 32'h0} + 80'(lo_prod);
      S_CMP: stat_hit <= (n >= min_samples) && (el > soft_floor) && d2_pos &&
                         ({4'h0, lhs} > {rhs9, 16'h0000});
      default: ;
    endcase
  end

  // sequencer
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_LOAD;
      S_LOAD: state_next = S_DIV;
      S_DIV:  if (div_rsp.done) state_next = S_MEAN;
      S_MEAN: state_next = S_DEV;
      S_DEV:  state_next = S_P1;
      S_P1:   state_next = S_P2;
      S_P2:   state_next = S_P3;
      S_P3:   state_next = S_P4;
      S_P4:   state_next = S_P5;
      S_P5:   state_next = S_CMP;
      S_CMP:  state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // governor state
  logic [lsag_pkg::PAR_BITS-1:0]   par, par_next;
  logic [lsag_pkg::DELAY_BITS-1:0] delay, delay_next;
  logic [lsag_pkg::RUN_BITS-1:0]   clean, clean_next;
  logic                            spike, changed, warn;
  logic [lsag_pkg::CNT_BITS-1:0]   spikes_next;
  logic [lsag_pkg::PAR_BITS-1:0]   half, ceil;
  logic [lsag_pkg::RUN_BITS-1:0]   run_inc;
  logic                            finish;

  assign finish = (state == S_DONE) && out_free;

  // spike decision and concurrency update
  always_comb begin
    spike       = stat_hit || (el >= hard_limit);
    par_next    = par;
    delay_next  = delay;
    clean_next  = clean;
    changed     = 1'b0;
    warn        = 1'b0;
    spikes_next = spikes;
    half        = par >> 1;
    ceil        = (core_count < lsag_pkg::PAR_CEIL_MIN) ? lsag_pkg::PAR_CEIL_MIN : core_count;
    run_inc     = (clean != lsag_pkg::RUN_MAX) ? clean + 4'd1 : clean;
    if (spike) begin
      if (spikes != lsag_pkg::CNT_MAX) spikes_next = spikes + 16'd1;
      par_next   = (half < lsag_pkg::PAR_FLOOR) ? lsag_pkg::PAR_FLOOR : half;
      delay_next = backoff;
      clean_next = '0;
      changed    = 1'b1;
      warn       = (spikes_next == lsag_pkg::WARN_LVL0) ||
                   (spikes_next == lsag_pkg::WARN_LVL1) ||
                   (spikes_next == lsag_pkg::WARN_LVL2);
    end else begin
      clean_next = run_inc;
      if (run_inc >= ramp_reads) begin
        clean_next = '0;
        delay_next = '0;
        if (par < ceil) begin
          par_next = par + 9'd1;
          changed  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      par   <= lsag_pkg::PAR_RST;
      delay <= '0;
      clean <= '0;
    end else if (finish) begin
      par   <= par_next;
      delay <= delay_next;
      clean <= clean_next;
    end
  end

  // store write-back
  assign st_we          = finish;
  assign st_wr.samples  = n;
  assign st_wr.mean     = nm;
  assign st_wr.spread   = spread_new;
  assign st_wr.spikes   = spikes_next;

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (finish) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.spike               <= spike;
      out_data.concurrency         <= par_next;
      out_data.concurrency_changed <= changed;
      out_data.throttle_ms         <= delay_next;
      out_data.drive_warning       <= warn;
      out_data.anomaly_total       <= spikes_next;
      out_data.mean_ms             <= nm[31:16];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/lsag_checker.sv
// lsag_checker: port-level assertions for the governor core, bound to the top level
// depends on lsag_pkg and latency_spike_aimd_governor_core
`timescale 1ns / 1ps
`default_nettype none
module lsag_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire lsag_pkg::out_item_t out_data
);

  // one item at a time: busy right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // concurrency never drops below its floor
  a_par_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.concurrency >= lsag_pkg::PAR_FLOOR))
    else $error("concurrency below floor");

  // every spike reports a concurrency change
  a_spike_changes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.spike |-> out_data.concurrency_changed)
    else $error("spike without concurrency change");

  // a warning only comes with a spike
  a_warn_spike: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_warning |-> out_data.spike)
    else $error("drive warning without spike");

endmodule

bind latency_spike_aimd_governor_core lsag_checker u_lsag_checker (.*);
`default_nettype wire
